// ===== rtl/core/skm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types and constants for the scan-code modifier tracker and key queue.
// ----------------------------------------------------------------------------
package skm_pkg;

    localparam int DEFAULT_RING_DEPTH = 32;

    localparam int SCAN_W    = 8;
    localparam int CODE_W    = 7;
    localparam int ENTRY_W   = 8;
    localparam int FLAGS_W   = 5;
    localparam int MASK_W    = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_HIGH = 2'd3;

    localparam logic [CODE_W-1:0] RIGHT_CODE_MASK = 7'h60;
    localparam logic [CODE_W-1:0] LSHIFT_CODE     = 7'h2A;
    localparam logic [CODE_W-1:0] RSHIFT_CODE     = 7'h36;
    localparam logic [CODE_W-1:0] CTRL_CODE       = 7'h1D;
    localparam logic [CODE_W-1:0] KEY_ALT         = 7'h38;
    localparam logic [CODE_W-1:0] QUEUE_LIMIT     = 7'h60;

    localparam int FLAG_SHIFT = 0;
    localparam int FLAG_CTRL  = 1;
    localparam int FLAG_ALT   = 2;
    localparam int FLAG_ALTGR = 3;
    localparam int FLAG_RIGHT = 4;

    typedef struct packed {
        logic               pop_hit;
        logic               enqueued;
        logic [FLAGS_W-1:0] flags;
        logic               has_key;
    } skm_step_t;

endpackage
`default_nettype wire

// ===== rtl/core/skm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skm_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface skm_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [skm_pkg::SCAN_W-1:0] scan_byte;

    modport source (output valid, command, scan_byte, input ready);
    modport sink   (input valid, command, scan_byte, output ready);
endinterface

interface skm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          key_valid;
    logic [skm_pkg::CODE_W-1:0]    key_code;
    logic                          key_shifted;
    logic                          enqueued;
    logic [skm_pkg::FLAGS_W-1:0]   modifier_flags;
    logic                          has_key;

    modport source (output valid, key_valid, key_code, key_shifted, enqueued,
                    modifier_flags, has_key, input ready);
    modport sink   (input valid, key_valid, key_code, key_shifted, enqueued,
                    modifier_flags, has_key, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/skm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/skm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skm_ctrl
// Modifier flags, presence masks and ring pointers; drives the ring RAM ports.
// ----------------------------------------------------------------------------
module skm_ctrl #(
    parameter int RING_DEPTH = skm_pkg::DEFAULT_RING_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [skm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [skm_pkg::MASK_W-1:0]       cfg_data,
    input  wire logic                             accept,
    input  wire logic                             command,
    input  wire logic [skm_pkg::SCAN_W-1:0]       scan_byte,
    output logic                                  ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]         ram_waddr,
    output logic [skm_pkg::ENTRY_W-1:0]           ram_wdata,
    output logic                                  ram_re,
    output logic [$clog2(RING_DEPTH)-1:0]         ram_raddr,
    output skm_pkg::skm_step_t                    step
);
    import skm_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [MASK_W-1:0]  plain_low_reg, plain_high_reg, shift_low_reg, shift_high_reg;
    logic [FLAGS_W-1:0] mod_reg, mod_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;

    logic [CODE_W-1:0]  code;
    logic               release_bit;
    logic               is_shift;
    logic [127:0]       mask;
    logic               push;
    logic               pop_hit;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign code        = scan_byte[CODE_W-1:0];
    assign release_bit = scan_byte[SCAN_W-1];
    assign is_shift    = (code == LSHIFT_CODE) || (code == RSHIFT_CODE);
    assign mask        = mod_next[FLAG_SHIFT] ? {32'b0, shift_high_reg, shift_low_reg}
                                              : {32'b0, plain_high_reg, plain_low_reg};

    always_comb
    begin
        mod_next    = mod_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        push        = 1'b0;
        pop_hit     = 1'b0;
        if (accept)
        begin
            if (command == CMD_POP)
            begin
                if (wr_ptr_reg != rd_ptr_reg)
                begin
                    pop_hit     = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                end
            end
            else if (release_bit)
            begin
                if (is_shift)
                    mod_next[FLAG_SHIFT] = 1'b0;
                if (code == CTRL_CODE)
                    mod_next[FLAG_CTRL] = 1'b0;
                if (code == KEY_ALT)
                begin
                    if (mod_reg[FLAG_RIGHT])
                        mod_next[FLAG_ALTGR] = 1'b0;
                    else
                        mod_next[FLAG_ALT] = 1'b0;
                end
                if ((code & RIGHT_CODE_MASK) != '0)
                    mod_next[FLAG_RIGHT] = 1'b0;
            end
            else
            begin
                if ((code & RIGHT_CODE_MASK) != '0)
                    mod_next[FLAG_RIGHT] = 1'b1;
                priority if (is_shift)
                    mod_next[FLAG_SHIFT] = 1'b1;
                else if (code == CTRL_CODE)
                    mod_next[FLAG_CTRL] = 1'b1;
                else if (code == KEY_ALT)
                begin
                    if (mod_next[FLAG_RIGHT])
                        mod_next[FLAG_ALTGR] = 1'b1;
                    else
                        mod_next[FLAG_ALT] = 1'b1;
                end
                else
                    mod_next = mod_next;
                if ((code < QUEUE_LIMIT) && mask[code])
                begin
                    push        = 1'b1;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg        <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            plain_low_reg  <= '0;
            plain_high_reg <= '0;
            shift_low_reg  <= '0;
            shift_high_reg <= '0;
        end
        else
        begin
            mod_reg    <= mod_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PLAIN_LOW:  plain_low_reg  <= cfg_data;
                    CFG_PLAIN_HIGH: plain_high_reg <= cfg_data;
                    CFG_SHIFT_LOW:  shift_low_reg  <= cfg_data;
                    CFG_SHIFT_HIGH: shift_high_reg <= cfg_data;
                endcase
            end
        end
    end

    assign ram_we    = push;
    assign ram_waddr = wr_ptr_reg;
    assign ram_wdata = {mod_next[FLAG_SHIFT], code};
    assign ram_re    = pop_hit;
    assign ram_raddr = rd_ptr_reg;

    assign step.pop_hit  = pop_hit;
    assign step.enqueued = push;
    assign step.flags    = mod_next;
    assign step.has_key  = (wr_ptr_next != rd_ptr_next);

endmodule
`default_nettype wire

// ===== rtl/core/scancode_modifier_key_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_modifier_key_fifo
// Set-1 scan-code modifier tracker with a ring of queued key presses.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the output stalls: a scan byte
// updates the shift/ctrl/alt/altgr/right flags and may push a key into the
// ring, a pop reads the oldest key. The response appears in the cycle after
// acceptance, set by the registered read port of the ring RAM, and sits in a
// single output register that keeps accepting while it drains. The ring needs
// no clearing pass after reset; the masks are written over the cfg port.
module scancode_modifier_key_fifo #(
    parameter int RING_DEPTH = skm_pkg::DEFAULT_RING_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [skm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [skm_pkg::MASK_W-1:0]    cfg_data,
    skm_req_if.sink                            req,
    skm_rsp_if.source                          rsp
);
    import skm_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic                accept;
    logic                ram_we, ram_re;
    logic [PTR_W-1:0]    ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    skm_step_t           step;

    logic                s1_valid_reg, s1_valid_next;
    skm_step_t           s1_step_reg;

    assign req.ready = !s1_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    skm_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .command   (req.command),
        .scan_byte (req.scan_byte),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .step      (step)
    );

    skm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (rsp.ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_step_reg <= step;
        end
    end

    assign rsp.valid          = s1_valid_reg;
    assign rsp.key_valid      = s1_step_reg.pop_hit;
    assign rsp.key_code       = s1_step_reg.pop_hit ? ram_rdata[CODE_W-1:0] : '0;
    assign rsp.key_shifted    = s1_step_reg.pop_hit && ram_rdata[ENTRY_W-1];
    assign rsp.enqueued       = s1_step_reg.enqueued;
    assign rsp.modifier_flags = s1_step_reg.flags;
    assign rsp.has_key        = s1_step_reg.has_key;

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction did not reach the output register");

    a_pop_xor_push: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.key_valid && rsp.enqueued))
        else $error("response both popped and pushed a key");

    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ring written and read in the same cycle");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> !$past(accept) && $stable(ram_rdata))
        else $error("ring read data changed under a stalled response");
`endif

endmodule
`default_nettype wire

// ===== verif/scancode_modifier_key_fifo_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_modifier_key_fifo_tb
// Self-checking testbench for the scan-code modifier tracker and key queue.
// A table of directed transactions covers the modifier keys, the right-flag
// test, the queue limit and pops on an empty queue. Random phases follow,
// each under its own set of presence masks, and are checked against a
// predictor of the modifier flags and the key ring. The sender idles in
// bursts and the receiver stalls on a pattern, but not in the first random phase.
// ----------------------------------------------------------------------------
module scancode_modifier_key_fifo_tb;

    import skm_pkg::*;

    localparam int RING_DEPTH  = DEFAULT_RING_DEPTH;
    localparam int HALF_PERIOD = 10;
    localparam int IDLE_LIMIT  = 200;
    localparam int SHOW_LIMIT  = 10;
    localparam int N_DIRECTED  = 25;

    typedef struct packed {
        logic               key_valid;
        logic [CODE_W-1:0]  key_code;
        logic               key_shifted;
        logic               enqueued;
        logic [FLAGS_W-1:0] flags;
        logic               has_key;
    } key_result_t;

    typedef struct packed {
        logic              command;
        logic [SCAN_W-1:0] sbyte;
        logic              typed;
        key_result_t       result;
    } stim_row_t;

    localparam key_result_t NO_RESULT = '0;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{CMD_POP,  8'h00, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b0, 5'h00, 1'b0}},
        '{CMD_SCAN, 8'h00, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b1, 5'h00, 1'b1}},
        '{CMD_POP,  8'hFF, 1'b1, '{1'b1, 7'h00, 1'b0, 1'b0, 5'h00, 1'b0}},
        '{CMD_SCAN, 8'h2A, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h1D, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h38, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'hB8, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'hE0, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h5F, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h60, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h7F, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'hAA, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h36, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h9D, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'hB6, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h80, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'hFF, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'hB8, 1'b0, NO_RESULT},
        '{CMD_SCAN, 8'h10, 1'b0, NO_RESULT},
        '{CMD_POP,  8'h55, 1'b0, NO_RESULT},
        '{CMD_POP,  8'hAA, 1'b0, NO_RESULT},
        '{CMD_POP,  8'h00, 1'b0, NO_RESULT},
        '{CMD_POP,  8'h7F, 1'b0, NO_RESULT},
        '{CMD_POP,  8'h80, 1'b0, NO_RESULT},
        '{CMD_POP,  8'hFF, 1'b0, NO_RESULT}
    };

    localparam logic [CODE_W-1:0] MODIFIER_CODES [4] = '{
        LSHIFT_CODE, RSHIFT_CODE, CTRL_CODE, KEY_ALT
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_data;

    skm_req_if req_ch ();
    skm_rsp_if rsp_ch ();

    logic        row_typed;
    key_result_t row_result;
    logic [15:0] stall_pattern;
    logic [3:0]  stall_beat;
    bit          gaps_on;
    int unsigned burst_left;
    int unsigned idle_cycles;
    int unsigned fail_count;

    logic [MASK_W-1:0]  plain_lo_mask;
    logic [MASK_W-1:0]  plain_hi_mask;
    logic [MASK_W-1:0]  shift_lo_mask;
    logic [MASK_W-1:0]  shift_hi_mask;
    logic [FLAGS_W-1:0] mods;
    int unsigned        ring_wr;
    int unsigned        ring_rd;
    logic [ENTRY_W-1:0] key_ring [RING_DEPTH];

    key_result_t pending_keys [$];

    scancode_modifier_key_fifo #(
        .RING_DEPTH (RING_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic key_result_t apply_key_item(input logic cmd,
                                                   input logic [SCAN_W-1:0] sbyte);
        key_result_t       r;
        logic [CODE_W-1:0] code;
        logic              shifted;
        logic              hit;
        logic [MASK_W-1:0] lo;
        logic [MASK_W-1:0] hi;
        int unsigned       idx;
        r    = '0;
        code = sbyte[CODE_W-1:0];
        idx  = code;
        if (cmd == CMD_SCAN) begin
            if (sbyte[SCAN_W-1]) begin
                if (code == LSHIFT_CODE || code == RSHIFT_CODE)
                    mods[FLAG_SHIFT] = 1'b0;
                if (code == CTRL_CODE)
                    mods[FLAG_CTRL] = 1'b0;
                if (code == KEY_ALT)
                begin
                    if (mods[FLAG_RIGHT])
                        mods[FLAG_ALTGR] = 1'b0;
                    else
                        mods[FLAG_ALT] = 1'b0;
                end
                if ((code & RIGHT_CODE_MASK) != '0)
                    mods[FLAG_RIGHT] = 1'b0;
            end
            else
            begin
                if ((code & RIGHT_CODE_MASK) != '0)
                    mods[FLAG_RIGHT] = 1'b1;
                if (code == LSHIFT_CODE || code == RSHIFT_CODE)
                    mods[FLAG_SHIFT] = 1'b1;
                else if (code == CTRL_CODE)
                    mods[FLAG_CTRL] = 1'b1;
                else if (code == KEY_ALT)
                begin
                    if (mods[FLAG_RIGHT])
                        mods[FLAG_ALTGR] = 1'b1;
                    else
                        mods[FLAG_ALT] = 1'b1;
                end
                if (code < QUEUE_LIMIT)
                begin
                    shifted = mods[FLAG_SHIFT];
                    lo      = shifted ? shift_lo_mask : plain_lo_mask;
                    hi      = shifted ? shift_hi_mask : plain_hi_mask;
                    hit     = (idx < MASK_W) ? lo[idx] : hi[idx - MASK_W];
                    if (hit)
                    begin
                        key_ring[ring_wr] = {shifted, code};
                        ring_wr           = (ring_wr + 1) % RING_DEPTH;
                        r.enqueued        = 1'b1;
                    end
                end
            end
        end
        else if (ring_wr != ring_rd)
        begin
            r.key_valid   = 1'b1;
            r.key_code    = key_ring[ring_rd][CODE_W-1:0];
            r.key_shifted = key_ring[ring_rd][ENTRY_W-1];
            ring_rd       = (ring_rd + 1) % RING_DEPTH;
        end
        r.flags   = mods;
        r.has_key = (ring_wr != ring_rd);
        return r;
    endfunction

    task automatic check_key(input key_result_t want, input key_result_t got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
                $display({"%0t mismatch: expected valid=%0b code=%02h shifted=%0b enq=%0b",
                          " flags=%02h has=%0b, got valid=%0b code=%02h shifted=%0b",
                          " enq=%0b flags=%02h has=%0b"},
                         $time, want.key_valid, want.key_code, want.key_shifted,
                         want.enqueued, want.flags, want.has_key,
                         got.key_valid, got.key_code, got.key_shifted,
                         got.enqueued, got.flags, got.has_key);
        end
    endtask

    // predict on request acceptance, check on response acceptance
    always @(posedge clk)
    begin
        key_result_t predicted;
        key_result_t got;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted = apply_key_item(req_ch.command, req_ch.scan_byte);
                pending_keys.push_back(row_typed ? row_result : predicted);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.key_valid, rsp_ch.key_code, rsp_ch.key_shifted,
                        rsp_ch.enqueued, rsp_ch.modifier_flags, rsp_ch.has_key};
                if (pending_keys.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("%0t unexpected transaction on response channel", $time);
                end
                else
                    check_key(pending_keys.pop_front(), got);
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= stall_pattern[stall_beat];
        stall_beat   <= stall_beat + 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PLAIN_LOW:  plain_lo_mask = value;
            CFG_PLAIN_HIGH: plain_hi_mask = value;
            CFG_SHIFT_LOW:  shift_lo_mask = value;
            CFG_SHIFT_HIGH: shift_hi_mask = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_masks(input logic [MASK_W-1:0] p_lo, input logic [MASK_W-1:0] p_hi,
                               input logic [MASK_W-1:0] s_lo, input logic [MASK_W-1:0] s_hi);
        write_reg(CFG_PLAIN_LOW, p_lo);
        write_reg(CFG_PLAIN_HIGH, p_hi);
        write_reg(CFG_SHIFT_LOW, s_lo);
        write_reg(CFG_SHIFT_HIGH, s_hi);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic cmd, input logic [SCAN_W-1:0] sbyte,
                             input logic typed, input key_result_t result);
        int unsigned gap;
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.scan_byte <= sbyte;
        row_typed        <= typed;
        row_result       <= result;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_keys.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SCAN_W-1:0] pick_scan_byte();
        int unsigned sel;
        logic        rel;
        sel = $urandom_range(0, 99);
        rel = 1'($urandom_range(0, 1));
        if (sel < 30)
            return {rel, MODIFIER_CODES[$urandom_range(0, 3)]};
        if (sel < 40)
            return {rel, 7'($urandom_range(QUEUE_LIMIT, 127))};
        if (sel < 80)
            return {1'b0, 7'($urandom_range(0, QUEUE_LIMIT - 1))};
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_phase(input logic [MASK_W-1:0] p_lo, input logic [MASK_W-1:0] p_hi,
                             input logic [MASK_W-1:0] s_lo, input logic [MASK_W-1:0] s_hi,
                             input int unsigned pop_pct, input int unsigned count,
                             input bit idle_on);
        logic cmd;
        write_masks(p_lo, p_hi, s_lo, s_hi);
        gaps_on       = idle_on;
        stall_pattern <= idle_on ? (16'($urandom) | 16'h0001) : 16'hFFFF;
        for (int unsigned n = 0; n < count; n++)
        begin
            cmd = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_SCAN;
            send_item(cmd, (cmd == CMD_POP) ? 8'($urandom) : pick_scan_byte(),
                      1'b0, NO_RESULT);
        end
        wait_drained();
    endtask

    function automatic logic [MASK_W-1:0] random_mask();
        return {16'($urandom), 32'($urandom)};
    endfunction

    initial
    begin
        logic [MASK_W-1:0] all_ones;
        all_ones          = '1;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_PLAIN_LOW;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_SCAN;
        req_ch.scan_byte  = '0;
        rsp_ch.ready      = 1'b0;
        row_typed         = 1'b0;
        row_result        = NO_RESULT;
        stall_pattern     = 16'hFFFF;
        stall_beat        = '0;
        gaps_on           = 1'b1;
        burst_left        = 0;
        idle_cycles       = 0;
        fail_count        = 0;
        plain_lo_mask     = '0;
        plain_hi_mask     = '0;
        shift_lo_mask     = '0;
        shift_hi_mask     = '0;
        mods              = '0;
        ring_wr           = 0;
        ring_rd           = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_masks(all_ones, all_ones, all_ones, all_ones);
        stall_pattern <= 16'hB5ED;
        for (int unsigned i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED_ROWS[i].command, DIRECTED_ROWS[i].sbyte,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        wait_drained();

        run_phase(all_ones, all_ones, all_ones, all_ones, 8, 90, 1'b0);
        run_phase('0, '0, all_ones, all_ones, 40, 90, 1'b1);
        run_phase(random_mask(), random_mask(), random_mask(), random_mask(), 45, 90, 1'b1);
        run_phase({24{2'b10}}, {24{2'b01}}, {24{2'b01}}, {24{2'b10}}, 35, 90, 1'b1);
        run_phase('0, '0, '0, '0, 30, 90, 1'b1);

        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_keys.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
